>>> hdl/fsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsb_pkg;

   // record slots and parameter list limits
   localparam int NUM_SLAVES_DEF = 32;
   localparam int MAX_PARAMS     = 16;

   // configuration register indexes
   localparam logic REG_RETRY_LIMIT = 1'b0;
   localparam logic REG_FAULT_MASK  = 1'b1;

   localparam logic [7:0] RETRY_LIMIT_RST = 8'd3;
   localparam logic [7:0] FAULT_MASK_RST  = 8'd71;

   typedef enum logic [1:0] {
      OP_POLL   = 2'd0,
      OP_ACCESS = 2'd1,
      OP_REINIT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      MODE_OFFLINE = 3'd0,
      MODE_DIAG1   = 3'd1,
      MODE_SETPRM  = 3'd2,
      MODE_CHKCFG  = 3'd3,
      MODE_DIAG2   = 3'd4,
      MODE_EXCH    = 3'd5,
      MODE_FAULT   = 3'd6
   } mode_type;

   // one incoming word
   typedef struct packed {
      logic [1:0] op;
      logic [4:0] slave;
      logic       comm_ok;
      logic [7:0] stat_1;
      logic [7:0] stat_2;
      logic [7:0] stat_3;
      logic       has_cfg_data;
      logic [4:0] param_count;
      logic       param_wants_write;
      logic       param_write_ok;
      logic       exchange_ok;
   } item_type;

   // per-slave bring-up record
   typedef struct packed {
      mode_type    mode;
      logic        frame_bit;
      logic        frame_valid;
      logic [7:0]  fail_run;
      logic [4:0]  param_index;
      logic [23:0] diag;
      logic [31:0] error_cnt;
      logic [31:0] retry_cnt;
      logic [31:0] cycle_cnt;
   } rec_type;

   localparam rec_type REC_RESET = '0;

   typedef struct packed {
      logic [7:0] retry_limit;
      logic [7:0] fault_mask;
   } cfg_type;

endpackage

`default_nettype wire

>>> hdl/fieldbus_slave_bringup_fsm_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bring-up sequencer for the slaves of a fieldbus master, one record per slave.
// Each request word is a poll step, an on-demand access completion or a record
// re-initialisation for one slave; each produces exactly one response word with
// the slave's record after the step. Throughput is one word per clock while the
// response side is not stalled: the record is read from a registered-read RAM
// as the request is accepted, then updated and written back as the word moves
// into the response register, with a bypass of the last write so back-to-back
// words to the same slave see fresh data. Records reset to offline/zero through
// per-slave valid bits, so no clearing pass is needed. A slave index at or above
// NUM_SLAVES changes nothing and returns an all-zero response.
module fieldbus_slave_bringup_fsm_top #(
   parameter int NUM_SLAVES = fsb_pkg::NUM_SLAVES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [4:0]  req_slave,
   input  wire logic        req_comm_ok,
   input  wire logic [7:0]  req_stat_1,
   input  wire logic [7:0]  req_stat_2,
   input  wire logic [7:0]  req_stat_3,
   input  wire logic        req_has_cfg_data,
   input  wire logic [4:0]  req_param_count,
   input  wire logic        req_param_wants_write,
   input  wire logic        req_param_write_ok,
   input  wire logic        req_exchange_ok,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_slave_state,
   output logic             rsp_frame_bit,
   output logic             rsp_frame_bit_valid,
   output logic [23:0]      rsp_diag_bytes,
   output logic [7:0]       rsp_fail_run,
   output logic [4:0]       rsp_pending_param,
   output logic [31:0]      rsp_error_total,
   output logic [31:0]      rsp_retry_total,
   output logic [31:0]      rsp_cycle_total,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   import fsb_pkg::*;

   localparam int ADDR_W = (NUM_SLAVES > 1) ? $clog2(NUM_SLAVES) : 1;
   localparam int REC_W  = $bits(rec_type);

   cfg_type           cfg;
   item_type          req_item;
   item_type          s1_item_ff;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rec_type           rsp_rec_ff;
   rec_type           rsp_rec_in;
   logic [NUM_SLAVES-1:0] slot_valid_ff;
   logic              lw_valid_ff;
   logic [ADDR_W-1:0] lw_addr_ff;
   rec_type           lw_data_ff;
   logic              req_fire;
   logic              s1_fire;
   logic              out_free;
   logic              s1_in_range;
   logic [ADDR_W-1:0] s1_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [REC_W-1:0]  ram_rd;
   rec_type           cur_rec;
   rec_type           nxt_rec;
   logic              wr_en;

   fsb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // pack the request word
   always_comb begin
      req_item.op                = req_op;
      req_item.slave             = req_slave;
      req_item.comm_ok           = req_comm_ok;
      req_item.stat_1            = req_stat_1;
      req_item.stat_2            = req_stat_2;
      req_item.stat_3            = req_stat_3;
      req_item.has_cfg_data      = req_has_cfg_data;
      req_item.param_count       = req_param_count;
      req_item.param_wants_write = req_param_wants_write;
      req_item.param_write_ok    = req_param_write_ok;
      req_item.exchange_ok       = req_exchange_ok;
   end

   // handshake and pipeline flow
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign s1_fire   = s1_valid_ff & out_free;
   assign req_ready = ~s1_valid_ff | out_free;
   assign req_fire  = req_valid & req_ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign s1_addr     = ADDR_W'(s1_item_ff.slave);
   assign s1_in_range = 32'(s1_item_ff.slave) < NUM_SLAVES;
   // keep reading the held slave while stalled
   assign rd_addr     = req_fire ? ADDR_W'(req_slave) : s1_addr;

   fsb_ram #(
      .WIDTH  (REC_W),
      .DEPTH  (NUM_SLAVES),
      .ADDR_W (ADDR_W)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (nxt_rec),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   // current record: last-write bypass, then stored data, then reset value
   always_comb begin
      if (lw_valid_ff && lw_addr_ff == s1_addr) begin
         cur_rec = lw_data_ff;
      end else if (s1_in_range && slot_valid_ff[s1_addr]) begin
         cur_rec = rec_type'(ram_rd);
      end else begin
         cur_rec = REC_RESET;
      end
   end

   fsb_update u_update (
      .item (s1_item_ff),
      .cur  (cur_rec),
      .cfg  (cfg),
      .nxt  (nxt_rec)
   );

   assign wr_en      = s1_fire & s1_in_range;
   assign rsp_rec_in = s1_in_range ? nxt_rec : REC_RESET;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         lw_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            slot_valid_ff[s1_addr] <= 1'b1;
            lw_valid_ff            <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (s1_fire) begin
         rsp_rec_ff <= rsp_rec_in;
      end
      if (wr_en) begin
         lw_addr_ff <= s1_addr;
         lw_data_ff <= nxt_rec;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slave_state     = rsp_rec_ff.mode;
   assign rsp_frame_bit       = rsp_rec_ff.frame_bit;
   assign rsp_frame_bit_valid = rsp_rec_ff.frame_valid;
   assign rsp_diag_bytes      = rsp_rec_ff.diag;
   assign rsp_fail_run        = rsp_rec_ff.fail_run;
   assign rsp_pending_param   = rsp_rec_ff.param_index;
   assign rsp_error_total     = rsp_rec_ff.error_cnt;
   assign rsp_retry_total     = rsp_rec_ff.retry_cnt;
   assign rsp_cycle_total     = rsp_rec_ff.cycle_cnt;

endmodule

`default_nettype wire

>>> hdl/fsb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fsb_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/fsb_update.sv
`timescale 1ns / 1ps
`default_nettype none

module fsb_update (
   input  wire fsb_pkg::item_type item,
   input  wire fsb_pkg::rec_type  cur,
   input  wire fsb_pkg::cfg_type  cfg,
   output fsb_pkg::rec_type       nxt
);

   import fsb_pkg::*;

   logic [4:0] param_cnt;

   // parameter count clamped to the list size
   always_comb begin
      if (32'(item.param_count) > MAX_PARAMS) begin
         param_cnt = 5'(MAX_PARAMS);
      end else begin
         param_cnt = item.param_count;
      end
   end

   // next record for one word
   always_comb begin
      nxt = cur;
      case (op_type'(item.op))
         OP_POLL: begin
            case (cur.mode)
               MODE_OFFLINE: begin
                  nxt.mode = MODE_DIAG1;
               end
               MODE_DIAG1: begin
                  if (item.comm_ok) begin
                     nxt.diag        = {item.stat_3, item.stat_2, item.stat_1};
                     nxt.frame_bit   = ~nxt.frame_bit;
                     nxt.frame_valid = 1'b1;
                     nxt.mode        = MODE_SETPRM;
                  end else begin
                     nxt.error_cnt   = nxt.error_cnt + 32'd1;
                     nxt.mode        = MODE_OFFLINE;
                     nxt.frame_valid = 1'b0;
                  end
               end
               MODE_SETPRM, MODE_CHKCFG, MODE_DIAG2: begin
                  // parameterisation failure: restart or give up
                  if ((cur.mode == MODE_SETPRM && !item.comm_ok)
                      || (cur.mode == MODE_CHKCFG && item.has_cfg_data && !item.comm_ok)
                      || (cur.mode == MODE_DIAG2 && item.comm_ok
                          && (item.stat_1 & cfg.fault_mask) != 8'd0)) begin
                     if (cur.mode == MODE_DIAG2) begin
                        nxt.diag = {item.stat_3, item.stat_2, item.stat_1};
                     end
                     nxt.error_cnt   = nxt.error_cnt + 32'd1;
                     nxt.retry_cnt   = nxt.retry_cnt + 32'd1;
                     if (nxt.fail_run != 8'hFF) begin
                        nxt.fail_run = nxt.fail_run + 8'd1;
                     end
                     nxt.frame_valid = 1'b0;
                     if (nxt.fail_run >= cfg.retry_limit) begin
                        nxt.mode     = MODE_FAULT;
                        nxt.fail_run = 8'd0;
                     end else begin
                        nxt.mode     = MODE_OFFLINE;
                     end
                  end else if (cur.mode == MODE_DIAG2 && !item.comm_ok) begin
                     nxt.error_cnt   = nxt.error_cnt + 32'd1;
                     nxt.mode        = MODE_OFFLINE;
                     nxt.frame_valid = 1'b0;
                  end else begin
                     nxt.frame_bit   = ~nxt.frame_bit;
                     nxt.frame_valid = 1'b1;
                     case (cur.mode)
                        MODE_SETPRM: nxt.mode = MODE_CHKCFG;
                        MODE_CHKCFG: nxt.mode = MODE_DIAG2;
                        default: begin
                           nxt.diag     = {item.stat_3, item.stat_2, item.stat_1};
                           nxt.mode     = MODE_EXCH;
                           nxt.fail_run = 8'd0;
                        end
                     endcase
                  end
               end
               MODE_EXCH: begin
                  // walk pending initial parameter writes
                  if (cur.param_index < param_cnt) begin
                     if (!item.param_wants_write) begin
                        nxt.param_index = nxt.param_index + 5'd1;
                     end else if (item.param_write_ok) begin
                        nxt.frame_bit   = ~nxt.frame_bit;
                        nxt.frame_valid = 1'b1;
                        nxt.param_index = nxt.param_index + 5'd1;
                     end
                  end
                  // cyclic exchange outcome
                  if (item.exchange_ok) begin
                     nxt.frame_bit   = ~nxt.frame_bit;
                     nxt.frame_valid = 1'b1;
                     nxt.fail_run    = 8'd0;
                     nxt.cycle_cnt   = nxt.cycle_cnt + 32'd1;
                  end else begin
                     if (nxt.fail_run != 8'hFF) begin
                        nxt.fail_run = nxt.fail_run + 8'd1;
                     end
                     nxt.error_cnt = nxt.error_cnt + 32'd1;
                     if (nxt.fail_run >= cfg.retry_limit) begin
                        nxt.retry_cnt   = nxt.retry_cnt + 32'd1;
                        nxt.mode        = MODE_OFFLINE;
                        nxt.frame_valid = 1'b0;
                        nxt.fail_run    = 8'd0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         OP_ACCESS: begin
            if (item.comm_ok) begin
               nxt.frame_bit   = ~nxt.frame_bit;
               nxt.frame_valid = 1'b1;
            end
         end
         OP_REINIT: begin
            nxt = REC_RESET;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/fsb_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module fsb_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output fsb_pkg::cfg_type cfg
);

   import fsb_pkg::*;

   logic [7:0] retry_limit_ff;
   logic [7:0] fault_mask_ff;
   logic       wr_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RST;
         fault_mask_ff  <= FAULT_MASK_RST;
      end else if (wr_en) begin
         case (reg_sel)
            REG_RETRY_LIMIT: retry_limit_ff <= csr_pwdata[7:0];
            REG_FAULT_MASK:  fault_mask_ff  <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_RETRY_LIMIT: csr_prdata = {24'd0, retry_limit_ff};
         REG_FAULT_MASK:  csr_prdata = {24'd0, fault_mask_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg.retry_limit = retry_limit_ff;
   assign cfg.fault_mask  = fault_mask_ff;

endmodule

`default_nettype wire

>>> dv/fieldbus_slave_bringup_fsm_top_tb.sv
`timescale 1ns / 1ps

module fieldbus_slave_bringup_fsm_top_tb;
   import fsb_pkg::*;

   localparam int NUM_SLAVES = NUM_SLAVES_DEF;
   // op code the block does not use
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct {
      item_type    word;
      int unsigned gap;
   } queued_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [4:0]  req_slave = '0;
   logic        req_comm_ok = 1'b0;
   logic [7:0]  req_stat_1 = '0;
   logic [7:0]  req_stat_2 = '0;
   logic [7:0]  req_stat_3 = '0;
   logic        req_has_cfg_data = 1'b0;
   logic [4:0]  req_param_count = '0;
   logic        req_param_wants_write = 1'b0;
   logic        req_param_write_ok = 1'b0;
   logic        req_exchange_ok = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_slave_state;
   logic        rsp_frame_bit;
   logic        rsp_frame_bit_valid;
   logic [23:0] rsp_diag_bytes;
   logic [7:0]  rsp_fail_run;
   logic [4:0]  rsp_pending_param;
   logic [31:0] rsp_error_total;
   logic [31:0] rsp_retry_total;
   logic [31:0] rsp_cycle_total;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // pending words, predicted records and the predictor's own copy of the block
   queued_word_type outgoing_q[$];
   rec_type      record_q[$];
   rec_type      slave_rec[NUM_SLAVES];
   cfg_type      bus_cfg;
   item_type     on_bus;

   int unsigned  mismatch_count = 0;
   int unsigned  rsp_count = 0;
   int unsigned  stall_left = 0;
   logic         no_stall = 1'b0;

   fieldbus_slave_bringup_fsm_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_slave             (req_slave),
      .req_comm_ok           (req_comm_ok),
      .req_stat_1            (req_stat_1),
      .req_stat_2            (req_stat_2),
      .req_stat_3            (req_stat_3),
      .req_has_cfg_data      (req_has_cfg_data),
      .req_param_count       (req_param_count),
      .req_param_wants_write (req_param_wants_write),
      .req_param_write_ok    (req_param_write_ok),
      .req_exchange_ok       (req_exchange_ok),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_slave_state       (rsp_slave_state),
      .rsp_frame_bit         (rsp_frame_bit),
      .rsp_frame_bit_valid   (rsp_frame_bit_valid),
      .rsp_diag_bytes        (rsp_diag_bytes),
      .rsp_fail_run          (rsp_fail_run),
      .rsp_pending_param     (rsp_pending_param),
      .rsp_error_total       (rsp_error_total),
      .rsp_retry_total       (rsp_retry_total),
      .rsp_cycle_total       (rsp_cycle_total),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   // clock and reset
   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // one line per mismatch
   task automatic report_error(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("response %0d %s: got 0x%0h, want 0x%0h",
                                rsp_count, name, got, want));
   endtask

   // record helpers
   function automatic rec_type flip_frame(input rec_type r);
      r.frame_bit   = ~r.frame_bit;
      r.frame_valid = 1'b1;
      return r;
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   // failure while parameterising: back to offline, or fault once out of retries
   function automatic rec_type prm_failed(input rec_type r);
      r.error_cnt   = r.error_cnt + 1;
      r.retry_cnt   = r.retry_cnt + 1;
      r.fail_run    = sat_inc(r.fail_run);
      r.frame_valid = 1'b0;
      if (r.fail_run >= bus_cfg.retry_limit) begin
         r.mode     = MODE_FAULT;
         r.fail_run = '0;
      end else begin
         r.mode = MODE_OFFLINE;
      end
      return r;
   endfunction

   function automatic rec_type lost_slave(input rec_type r);
      r.error_cnt   = r.error_cnt + 1;
      r.mode        = MODE_OFFLINE;
      r.frame_valid = 1'b0;
      return r;
   endfunction

   // one poll step of the bring-up sequence
   function automatic rec_type poll_step(input rec_type r, input item_type w);
      logic [4:0] cap;
      cap = (w.param_count > MAX_PARAMS) ? 5'(MAX_PARAMS) : w.param_count;
      case (r.mode)
         MODE_OFFLINE: r.mode = MODE_DIAG1;
         MODE_DIAG1: begin
            if (w.comm_ok) begin
               r.diag = {w.stat_3, w.stat_2, w.stat_1};
               r      = flip_frame(r);
               r.mode = MODE_SETPRM;
            end else begin
               r = lost_slave(r);
            end
         end
         MODE_SETPRM: begin
            if (w.comm_ok) begin
               r      = flip_frame(r);
               r.mode = MODE_CHKCFG;
            end else begin
               r = prm_failed(r);
            end
         end
         MODE_CHKCFG: begin
            // no module config means the check is skipped
            if (!w.has_cfg_data || w.comm_ok) begin
               r      = flip_frame(r);
               r.mode = MODE_DIAG2;
            end else begin
               r = prm_failed(r);
            end
         end
         MODE_DIAG2: begin
            if (w.comm_ok) begin
               r.diag = {w.stat_3, w.stat_2, w.stat_1};
               if ((w.stat_1 & bus_cfg.fault_mask) != 8'h00) begin
                  r = prm_failed(r);
               end else begin
                  r          = flip_frame(r);
                  r.mode     = MODE_EXCH;
                  r.fail_run = '0;
               end
            end else begin
               r = lost_slave(r);
            end
         end
         MODE_EXCH: begin
            // one pending initial parameter per step, holds at the count
            if (r.param_index < cap) begin
               if (!w.param_wants_write) begin
                  r.param_index = r.param_index + 5'd1;
               end else if (w.param_write_ok) begin
                  r             = flip_frame(r);
                  r.param_index = r.param_index + 5'd1;
               end
            end
            if (w.exchange_ok) begin
               r          = flip_frame(r);
               r.fail_run = '0;
               r.cycle_cnt = r.cycle_cnt + 1;
            end else begin
               r.fail_run  = sat_inc(r.fail_run);
               r.error_cnt = r.error_cnt + 1;
               if (r.fail_run >= bus_cfg.retry_limit) begin
                  r.retry_cnt   = r.retry_cnt + 1;
                  r.mode        = MODE_OFFLINE;
                  r.frame_valid = 1'b0;
                  r.fail_run    = '0;
               end
            end
         end
         default: begin
            // fault holds until a reinit
         end
      endcase
      return r;
   endfunction

   // apply one accepted word to the slave records and queue the expected record
   task automatic advance_record(input item_type w);
      rec_type r;
      if (w.slave >= NUM_SLAVES) begin
         record_q.push_back(REC_RESET);
         return;
      end
      r = slave_rec[w.slave];
      case (w.op)
         OP_POLL:   r = poll_step(r, w);
         OP_ACCESS: if (w.comm_ok) r = flip_frame(r);
         OP_REINIT: r = REC_RESET;
         default: begin
            // spare op leaves the record alone
         end
      endcase
      slave_rec[w.slave] = r;
      record_q.push_back(r);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            advance_record(on_bus);
         if (!req_valid || req_ready) begin
            if (outgoing_q.size() != 0 && outgoing_q[0].gap != 0) begin
               outgoing_q[0].gap--;
               req_valid <= 1'b0;
            end else if (outgoing_q.size() != 0) begin
               on_bus                = outgoing_q.pop_front().word;
               req_op                <= on_bus.op;
               req_slave             <= on_bus.slave;
               req_comm_ok           <= on_bus.comm_ok;
               req_stat_1            <= on_bus.stat_1;
               req_stat_2            <= on_bus.stat_2;
               req_stat_3            <= on_bus.stat_3;
               req_has_cfg_data      <= on_bus.has_cfg_data;
               req_param_count       <= on_bus.param_count;
               req_param_wants_write <= on_bus.param_wants_write;
               req_param_write_ok    <= on_bus.param_write_ok;
               req_exchange_ok       <= on_bus.exchange_ok;
               req_valid             <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      rec_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (record_q.size() == 0) begin
               report_error($sformatf("response %0d with no word outstanding", rsp_count));
            end else begin
               e = record_q.pop_front();
               check_field("slave_state", 32'(rsp_slave_state), 32'(e.mode));
               check_field("frame_bit", 32'(rsp_frame_bit), 32'(e.frame_bit));
               check_field("frame_bit_valid", 32'(rsp_frame_bit_valid),
                           32'(e.frame_valid));
               check_field("diag_bytes", 32'(rsp_diag_bytes), 32'(e.diag));
               check_field("fail_run", 32'(rsp_fail_run), 32'(e.fail_run));
               check_field("pending_param", 32'(rsp_pending_param), 32'(e.param_index));
               check_field("error_total", rsp_error_total, e.error_cnt);
               check_field("retry_total", rsp_retry_total, e.retry_cnt);
               check_field("cycle_total", rsp_cycle_total, e.cycle_cnt);
            end
            rsp_count++;
            stall_left = no_stall ? 0 : $urandom_range(0, 7);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // apb access: setup then access, completes at the edge with pready high
   task automatic csr_access(input logic wr, input logic idx, input logic [7:0] data);
      logic [31:0] want;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'h0, data};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      want = {24'h0, (idx == REG_RETRY_LIMIT) ? bus_cfg.retry_limit : bus_cfg.fault_mask};
      if (wr) begin
         if (idx == REG_RETRY_LIMIT) bus_cfg.retry_limit = data;
         else bus_cfg.fault_mask = data;
      end else if (csr_prdata !== want) begin
         report_error($sformatf("register %0d read 0x%0h, want 0x%0h",
                                idx, csr_prdata, want));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] limit, input logic [7:0] mask);
      csr_access(1'b1, REG_RETRY_LIMIT, limit);
      csr_access(1'b1, REG_FAULT_MASK, mask);
      csr_access(1'b0, REG_RETRY_LIMIT, 8'h00);
      csr_access(1'b0, REG_FAULT_MASK, 8'h00);
   endtask

   // sender holds off until every outstanding word has come back
   task automatic drain();
      while (outgoing_q.size() != 0 || req_valid || record_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic item_type word_of(
      input logic [1:0] op, input logic [4:0] slv, input logic ok,
      input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] s3,
      input logic cfg, input logic [4:0] pcnt, input logic wants,
      input logic wok, input logic xok);
      item_type w;
      w.op                = op;
      w.slave             = slv;
      w.comm_ok           = ok;
      w.stat_1            = s1;
      w.stat_2            = s2;
      w.stat_3            = s3;
      w.has_cfg_data      = cfg;
      w.param_count       = pcnt;
      w.param_wants_write = wants;
      w.param_write_ok    = wok;
      w.exchange_ok       = xok;
      return w;
   endfunction

   task automatic queue_word(input item_type w, input int unsigned gap);
      queued_word_type q;
      q.word = w;
      q.gap  = gap;
      outgoing_q.push_back(q);
   endtask

   // random traffic: mostly runs of steps on one slave so records reach exchange
   task automatic load_random(input int n_words);
      int          made;
      int          len;
      logic [4:0]  slv;
      logic [4:0]  pcnt;
      logic        noisy;
      logic        burst;
      int unsigned pick;
      item_type    w;
      made = 0;
      while (made < n_words) begin
         slv   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 5));
         len   = $urandom_range(4, 24);
         noisy = ($urandom_range(0, 4) == 0);
         burst = ($urandom_range(0, 3) == 0);
         pcnt  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16));
         for (int k = 0; k < len && made < n_words; k++) begin
            if (noisy) begin
               w = item_type'({$urandom, $urandom});
               w.slave = ($urandom_range(0, 1) == 0) ? slv : w.slave;
            end else begin
               pick = $urandom_range(0, 99);
               w = word_of(pick < 88 ? OP_POLL : pick < 94 ? OP_ACCESS :
                           pick < 97 ? OP_REINIT : OP_SPARE,
                           slv, $urandom_range(0, 9) != 0,
                           ($urandom_range(0, 3) != 0) ? 8'($urandom) & ~bus_cfg.fault_mask
                                                       : 8'($urandom),
                           8'($urandom), 8'($urandom), 1'($urandom), pcnt,
                           1'($urandom), $urandom_range(0, 4) != 0,
                           $urandom_range(0, 6) != 0);
            end
            queue_word(w, burst ? 0 : $urandom_range(0, 7));
            made++;
         end
      end
   endtask

   // stimulus
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      bus_cfg.retry_limit = RETRY_LIMIT_RST;
      bus_cfg.fault_mask  = FAULT_MASK_RST;
      for (int s = 0; s < NUM_SLAVES; s++) slave_rec[s] = REC_RESET;

      // reset values read back, then written explicitly
      csr_access(1'b0, REG_RETRY_LIMIT, 8'h00);
      csr_access(1'b0, REG_FAULT_MASK, 8'h00);
      set_config(8'd3, 8'd71);

      // full bring-up of slave 0 with masked readiness, param walk, restart
      queue_word(word_of(OP_POLL, 5'd0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 5'd0,
                         1'b1, 1'b1, 1'b1), 1);
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      // no config data: check passes despite failed transaction
      queue_word(word_of(OP_POLL, 5'd0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 2);
      // second diagnosis rejected by the status mask
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h01, 8'h80, 8'h7F, 1'b1, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'hB8, 8'h5A, 8'hA5, 1'b1, 5'd0,
                         1'b0, 1'b0, 1'b0), 3);
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'hB8, 8'h00, 8'hFF, 1'b1, 5'd0,
                         1'b0, 1'b0, 1'b0), 7);
      // exchange: count above the maximum is clamped
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 5'd31,
                         1'b0, 1'b0, 1'b1), 0);
      queue_word(word_of(OP_POLL, 5'd0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd31,
                         1'b1, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 5'd2,
                         1'b1, 1'b1, 1'b1), 0);
      // parameters done: index holds at the count
      queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 5'd2,
                         1'b0, 1'b1, 1'b1), 1);
      queue_word(word_of(OP_ACCESS, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_ACCESS, 5'd0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_SPARE, 5'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 5'd16,
                         1'b1, 1'b1, 1'b1), 0);
      // three exchange failures restart the slave
      for (int k = 0; k < 3; k++)
         queue_word(word_of(OP_POLL, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                            1'b0, 1'b0, 1'b0), k);
      // highest slave: first diagnosis fails
      queue_word(word_of(OP_POLL, 5'd31, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd31, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_REINIT, 5'd0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      drain();

      // zero retry limit: first parameterisation failure goes to fault
      set_config(8'd0, 8'hFF);
      queue_word(word_of(OP_POLL, 5'd1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd1, 1'b1, 8'h12, 8'h34, 8'h56, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      queue_word(word_of(OP_POLL, 5'd1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 5'd0,
                         1'b0, 1'b0, 1'b1), 0);
      queue_word(word_of(OP_REINIT, 5'd1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                         1'b0, 1'b0, 1'b0), 0);
      drain();

      // random phases over several settings
      set_config(8'd3, 8'd71);
      load_random(90);
      drain();

      set_config(8'd0, 8'hFF);
      load_random(90);
      drain();

      no_stall = 1'b1;
      set_config(8'd255, 8'h00);
      load_random(90);
      drain();

      no_stall = 1'b0;
      set_config(8'd1, 8'($urandom));
      load_random(90);
      drain();

      set_config(8'd2, 8'd71);
      load_random(90);
      drain();

      if (mismatch_count == 0)
         $display("fieldbus_slave_bringup_fsm_top_tb: done, clean");
      else
         $display("fieldbus_slave_bringup_fsm_top_tb: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #3ms;
      $display("fieldbus_slave_bringup_fsm_top_tb: done, errors");
      $finish;
   end

endmodule

>>> sim.f
hdl/fsb_pkg.sv
hdl/fsb_ram.sv
hdl/fsb_update.sv
hdl/fsb_csr.sv
hdl/fieldbus_slave_bringup_fsm_top.sv
dv/fieldbus_slave_bringup_fsm_top_tb.sv
